// File: hdl/pf_enc_pkg.sv
package pf_enc_pkg;

  localparam int SIDE      = 5;
  localparam int CELLS     = SIDE * SIDE;
  localparam int CODE_W    = 5;
  localparam int POS_W     = 3;
  localparam int IDX_W     = 5;
  localparam int ROWS2_W   = 2 * SIDE * CODE_W;
  localparam int ROW_W     = SIDE * CODE_W;
  localparam int CFG_IDX_W = 2;

  // Letter codes, A=0 .. Z=25
  localparam logic [CODE_W-1:0] LETTER_I = 5'd8;
  localparam logic [CODE_W-1:0] LETTER_J = 5'd9;
  localparam logic [CODE_W-1:0] LETTER_X = 5'd23;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BOTTOM = 2'd2;

  typedef logic [CODE_W-1:0] code_t;

  // Key square, entry k = row*5 + col
  typedef logic [CELLS-1:0][CODE_W-1:0] square_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
  } loc_t;

  typedef struct packed {
    code_t c0;
    code_t c1;
    logic  miss;
  } pair_t;

  function automatic code_t fold_j(input code_t ch);
    fold_j = (ch == LETTER_J) ? LETTER_I : ch;
  endfunction

  function automatic logic [POS_W-1:0] inc_wrap(input logic [POS_W-1:0] x);
    inc_wrap = (x == POS_W'(SIDE - 1)) ? '0 : x + POS_W'(1);
  endfunction

  function automatic code_t square_at(input square_t sq, input logic [POS_W-1:0] r,
                                      input logic [POS_W-1:0] c);
    logic [IDX_W-1:0] k;
    k = IDX_W'(r) * IDX_W'(SIDE) + IDX_W'(c);
    square_at = sq[k];
  endfunction

  // 25 parallel compares; scanning backward lets the first row-major match win
  function automatic loc_t locate(input square_t sq, input code_t ch);
    loc_t l;
    l = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (sq[IDX_W'(r * SIDE + c)] == ch) begin
          l.found = 1'b1;
          l.row   = POS_W'(r);
          l.col   = POS_W'(c);
        end
      end
    end
    locate = l;
  endfunction

  function automatic pair_t cipher_pair(input square_t sq, input code_t a, input code_t b);
    loc_t             la;
    loc_t             lb;
    logic [POS_W-1:0] r1;
    logic [POS_W-1:0] c1;
    logic [POS_W-1:0] r2;
    logic [POS_W-1:0] c2;
    pair_t            p;
    la = locate(sq, a);
    lb = locate(sq, b);
    r1 = la.row;
    c1 = la.col;
    r2 = lb.row;
    c2 = lb.col;
    if (la.row == lb.row) begin
      c1 = inc_wrap(la.col);
      c2 = inc_wrap(lb.col);
    end else if (la.col == lb.col) begin
      r1 = inc_wrap(la.row);
      r2 = inc_wrap(lb.row);
    end else begin
      c1 = lb.col;
      c2 = la.col;
    end
    if (la.found && lb.found) begin
      p.c0   = square_at(sq, r1, c1);
      p.c1   = square_at(sq, r2, c2);
      p.miss = 1'b0;
    end else begin
      p.c0   = a;
      p.c1   = b;
      p.miss = 1'b1;
    end
    cipher_pair = p;
  endfunction

endpackage

// File: hdl/playfair_digraph_encrypt.sv
// Channel  | Direction | Handshake              | Payload
// in_      | input     | in_valid / in_ready    | in_letter[4:0], in_message_end
// out_     | output    | out_valid / out_ready  | out_cipher_letter[4:0], out_pair_last,
//          |           |                        | out_not_in_square
// cfg_     | input     | cfg_valid / cfg_ready  | cfg_index[1:0], cfg_data[49:0]
//
// One letter is taken per cycle while in_ready is high. A pair is ciphered in the cycle
// its second letter (or an end-marked odd letter) is taken, is registered in the output
// or skid slot and goes out one per cycle while out_ready is high, first then second.
// Output pair slot plus one skid pair: in_ready drops only while the skid slot is full.
// Reset (rst_n low, synchronous) clears the key square, the held letter and both slots.
// cfg_ready is always high.
module playfair_digraph_encrypt (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [pf_enc_pkg::CODE_W-1:0]         in_letter,
  input  logic                                  in_message_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [pf_enc_pkg::CODE_W-1:0]         out_cipher_letter,
  output logic                                  out_pair_last,
  output logic                                  out_not_in_square,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pf_enc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pf_enc_pkg::ROWS2_W-1:0]        cfg_data
);
  import pf_enc_pkg::*;

  logic [ROWS2_W-1:0] key_top_r;
  logic [ROWS2_W-1:0] key_mid_r;
  logic [ROW_W-1:0]   key_bot_r;
  square_t            square;

  code_t held_letter_r;
  logic  held_valid_r;

  logic  main_valid_r;
  logic  main_phase_r;
  pair_t main_pair_r;
  logic  skid_valid_r;
  pair_t skid_pair_r;

  code_t ch_fold;
  code_t pair_a;
  code_t pair_b;
  pair_t new_pair;
  logic  in_fire;
  logic  pair_fire;
  logic  out_fire;
  logic  main_free;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_top_r <= '0;
      key_mid_r <= '0;
      key_bot_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_TOP:    key_top_r <= cfg_data;
        REG_KEY_MIDDLE: key_mid_r <= cfg_data;
        REG_KEY_BOTTOM: key_bot_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign square = {key_bot_r, key_mid_r, key_top_r};

  // Pair formation and cipher lookup
  assign ch_fold   = fold_j(in_letter);
  assign pair_a    = held_valid_r ? held_letter_r : ch_fold;
  assign pair_b    = held_valid_r ? ch_fold : LETTER_X;
  assign new_pair  = cipher_pair(square, pair_a, pair_b);

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign pair_fire = in_fire && (held_valid_r || in_message_end);
  assign out_fire  = out_valid && out_ready;
  assign main_free = !main_valid_r || (out_fire && main_phase_r);

  // Held first letter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_letter_r <= '0;
    end else if (in_fire) begin
      if (held_valid_r) begin
        held_valid_r  <= 1'b0;
        held_letter_r <= '0;
      end else if (!in_message_end) begin
        held_valid_r  <= 1'b1;
        held_letter_r <= ch_fold;
      end
    end
  end

  // Output pair slot and skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      main_phase_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (main_free) begin
        main_phase_r <= 1'b0;
        if (skid_valid_r) begin
          main_valid_r <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          main_valid_r <= pair_fire;
        end
      end else begin
        if (out_fire) begin
          main_phase_r <= 1'b1;
        end
        if (pair_fire) begin
          skid_valid_r <= 1'b1;
        end
      end
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_pair_r <= skid_valid_r ? skid_pair_r : new_pair;
    end
    if (!main_free && pair_fire) begin
      skid_pair_r <= new_pair;
    end
  end

  assign out_valid         = main_valid_r;
  assign out_cipher_letter = main_phase_r ? main_pair_r.c1 : main_pair_r.c0;
  assign out_pair_last     = main_phase_r;
  assign out_not_in_square = main_pair_r.miss;

  // Checks
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid pair held while output slot empty");

  a_phase_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    main_phase_r |-> main_valid_r)
    else $error("second-letter phase with no pair");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_pair_last) |=> (out_valid && out_pair_last))
    else $error("first letter of pair not followed by second");

  a_held_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && held_valid_r) |=> !held_valid_r)
    else $error("held letter survived pair completion");

  a_pair_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (pair_fire && !main_free) |=> skid_valid_r)
    else $error("pair lost while output slot busy");

endmodule

// File: tb/sv/playfair_digraph_encrypt_tb.sv
module playfair_digraph_encrypt_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pf_enc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned HOLD_CYCLES     = 150;
  localparam int unsigned CYCLE_LIMIT     = 250000;

  typedef enum {SQ_ALPHABET, SQ_SHUFFLED, SQ_DISTINCT, SQ_RANDOM, SQ_ONES, SQ_ZEROS}
    square_kind_t;

  typedef struct {
    code_t       letter;
    logic        msg_end;
    int unsigned gap;
  } plain_item_t;

  typedef struct {
    code_t letter;
    logic  last;
    logic  miss;
  } cipher_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  code_t                in_letter = '0;
  logic                 in_message_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  code_t                out_cipher_letter;
  logic                 out_pair_last;
  logic                 out_not_in_square;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROWS2_W-1:0]   cfg_data = '0;

  // Plaintext waiting to be offered and cipher letters waiting to come out
  plain_item_t    letter_queue [$];
  cipher_result_t cipher_expected [$];
  plain_item_t    offer;
  cipher_result_t want;
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;

  // Predicted key square and pairing state
  logic [ROWS2_W-1:0] key_top = '0;
  logic [ROWS2_W-1:0] key_middle = '0;
  logic [ROW_W-1:0]   key_bottom = '0;
  code_t              held_code = '0;
  logic               pair_open = 1'b0;

  // Receiver controls
  bit          rx_eager = 1'b0;
  bit          rx_hold_armed = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_wait = 0;
  int unsigned pause;

  code_t        square_plan [CELLS];
  square_kind_t phase_kind [RANDOM_PHASES] = '{SQ_SHUFFLED, SQ_DISTINCT, SQ_SHUFFLED,
                                               SQ_ONES, SQ_RANDOM, SQ_SHUFFLED, SQ_ZEROS,
                                               SQ_SHUFFLED, SQ_DISTINCT, SQ_RANDOM};

  playfair_digraph_encrypt uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_letter         (in_letter),
    .in_message_end    (in_message_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cipher_letter (out_cipher_letter),
    .out_pair_last     (out_pair_last),
    .out_not_in_square (out_not_in_square),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic code_t key_cell(input int unsigned k);
    if (k < 2 * SIDE) return key_top[CODE_W*k +: CODE_W];
    else if (k < 4 * SIDE) return key_middle[CODE_W*(k - 2*SIDE) +: CODE_W];
    else return key_bottom[CODE_W*(k - 4*SIDE) +: CODE_W];
  endfunction

  // first hit in row-major order
  function automatic logic find_cell(input code_t ch, output int unsigned row,
                                     output int unsigned col);
    row = 0;
    col = 0;
    for (int unsigned k = 0; k < CELLS; k++) begin
      if (key_cell(k) == ch) begin
        row = k / SIDE;
        col = k % SIDE;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void encipher_pair(input code_t lead, input code_t trail);
    int unsigned r1, c1, r2, c2, t;
    logic        hit1, hit2, miss;
    code_t       out1, out2;
    hit1 = find_cell(lead, r1, c1);
    hit2 = find_cell(trail, r2, c2);
    out1 = lead;
    out2 = trail;
    miss = 1'b1;
    if (hit1 && hit2) begin
      miss = 1'b0;
      if (r1 == r2) begin
        c1 = (c1 + 1) % SIDE;
        c2 = (c2 + 1) % SIDE;
      end else if (c1 == c2) begin
        r1 = (r1 + 1) % SIDE;
        r2 = (r2 + 1) % SIDE;
      end else begin
        t  = c1;
        c1 = c2;
        c2 = t;
      end
      out1 = key_cell(r1 * SIDE + c1);
      out2 = key_cell(r2 * SIDE + c2);
    end
    cipher_expected.push_back(cipher_result_t'{out1, 1'b0, miss});
    cipher_expected.push_back(cipher_result_t'{out2, 1'b1, miss});
  endfunction

  function automatic void encipher_letter(input code_t letter, input logic msg_end);
    code_t ch;
    ch = (letter == LETTER_J) ? LETTER_I : letter;
    if (pair_open) begin
      encipher_pair(held_code, ch);
      pair_open = 1'b0;
      held_code = '0;
    end else if (msg_end) begin
      // odd letter at message end pads with X
      encipher_pair(ch, LETTER_X);
    end else begin
      held_code = ch;
      pair_open = 1'b1;
    end
  endfunction

  function automatic void apply_key_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [ROWS2_W-1:0] data);
    case (idx)
      REG_KEY_TOP:    key_top = data;
      REG_KEY_MIDDLE: key_middle = data;
      REG_KEY_BOTTOM: key_bottom = data[ROW_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void queue_letter(input code_t ch, input logic msg_end, input bit idle);
    plain_item_t item;
    item.letter  = ch;
    item.msg_end = msg_end;
    item.gap     = (idle && $urandom_range(0, 1)) ? $urandom_range(1, 13) : 0;
    letter_queue.push_back(item);
  endfunction

  // mostly whole messages of letters; some stray letters with random end flags
  function automatic void queue_messages(input int unsigned count, input bit idle);
    int unsigned n, len;
    code_t       ch;
    n  = 0;
    ch = '0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_letter(code_t'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), idle);
        n++;
      end else begin
        len = $urandom_range(1, 12);
        for (int unsigned i = 0; i < len; i++) begin
          // keep the previous letter now and then to get doubled pairs
          if (i == 0 || $urandom_range(0, 7) != 0)
            ch = ($urandom_range(0, 15) == 0) ? code_t'($urandom_range(26, 31))
                                              : code_t'($urandom_range(0, 25));
          queue_letter(ch, i == len - 1, idle);
        end
        n += len;
      end
    end
  endfunction

  function automatic void plan_square(input square_kind_t kind);
    code_t       pool [32];
    code_t       t;
    int unsigned j, n;
    n = 0;
    case (kind)
      SQ_ALPHABET, SQ_SHUFFLED: begin
        for (int c = 0; c < 26; c++) begin
          if (code_t'(c) != LETTER_J) begin
            square_plan[n] = code_t'(c);
            n++;
          end
        end
      end
      SQ_DISTINCT: begin
        for (int c = 0; c < 32; c++) pool[c] = code_t'(c);
        for (int c = 31; c > 0; c--) begin
          j       = $urandom_range(0, c);
          t       = pool[c];
          pool[c] = pool[j];
          pool[j] = t;
        end
        for (int k = 0; k < CELLS; k++) square_plan[k] = pool[k];
      end
      SQ_RANDOM: begin
        for (int k = 0; k < CELLS; k++)
          square_plan[k] = $urandom_range(0, 1) ? code_t'($urandom_range(0, 7))
                                                : code_t'($urandom_range(0, 31));
      end
      SQ_ONES: begin
        for (int k = 0; k < CELLS; k++) square_plan[k] = '1;
      end
      default: begin
        for (int k = 0; k < CELLS; k++) square_plan[k] = '0;
      end
    endcase
    if (kind == SQ_SHUFFLED) begin
      for (int k = CELLS - 1; k > 0; k--) begin
        j              = $urandom_range(0, k);
        t              = square_plan[k];
        square_plan[k] = square_plan[j];
        square_plan[j] = t;
      end
    end
  endfunction

  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [ROWS2_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_square();
    logic [ROWS2_W-1:0] top_bits;
    logic [ROWS2_W-1:0] middle_bits;
    logic [ROWS2_W-1:0] bottom_bits;
    top_bits    = '0;
    middle_bits = '0;
    // junk above the bottom row must be dropped by the block
    bottom_bits = ROWS2_W'({$urandom, $urandom});
    for (int k = 0; k < 2 * SIDE; k++) begin
      top_bits[CODE_W*k +: CODE_W]    = square_plan[k];
      middle_bits[CODE_W*k +: CODE_W] = square_plan[k + 2*SIDE];
    end
    for (int k = 0; k < SIDE; k++)
      bottom_bits[CODE_W*k +: CODE_W] = square_plan[k + 4*SIDE];
    write_key(REG_UNUSED, ROWS2_W'({$urandom, $urandom}));
    write_key(REG_KEY_TOP, top_bits);
    write_key(REG_KEY_MIDDLE, middle_bits);
    write_key(REG_KEY_BOTTOM, bottom_bits);
  endtask

  // all letters taken and all cipher letters seen, then let the block settle
  task automatic wait_idle();
    do @(negedge clk);
    while (letter_queue.size() != 0 || in_valid || cipher_expected.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (letter_queue.size() != 0 && letter_queue[0].gap == 0) begin
        offer = letter_queue.pop_front();
        in_valid       <= 1'b1;
        in_letter      <= offer.letter;
        in_message_end <= offer.msg_end;
      end else begin
        in_valid <= 1'b0;
        if (letter_queue.size() != 0) letter_queue[0].gap = letter_queue[0].gap - 1;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rx_hold_armed && !hold_taken) begin
      // long back-pressure so the block fills and stalls its input
      out_ready  <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (rx_wait != 0) begin
      out_ready <= 1'b0;
      rx_wait   <= rx_wait - 1;
    end else if (out_valid && out_ready) begin
      pause = (rx_eager || $urandom_range(0, 1)) ? 0 : $urandom_range(1, 13);
      out_ready <= (pause == 0);
      rx_wait   <= (pause == 0) ? 0 : pause - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_key_write(cfg_index, cfg_data);
      if (in_valid && in_ready) encipher_letter(in_letter, in_message_end);
      if (out_valid && out_ready) begin
        if (cipher_expected.size() == 0) begin
          $display("%0t: unexpected transfer, cipher_letter %0d pair_last %0b not_in_square %0b",
                   $time, out_cipher_letter, out_pair_last, out_not_in_square);
          mismatch_count++;
        end else begin
          want = cipher_expected.pop_front();
          if (out_cipher_letter !== want.letter) begin
            $display("%0t: cipher_letter expected %0d, got %0d",
                     $time, want.letter, out_cipher_letter);
            mismatch_count++;
          end
          if (out_pair_last !== want.last) begin
            $display("%0t: pair_last expected %0b, got %0b", $time, want.last, out_pair_last);
            mismatch_count++;
          end
          if (out_not_in_square !== want.miss) begin
            $display("%0t: not_in_square expected %0b, got %0b",
                     $time, want.miss, out_not_in_square);
            mismatch_count++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("playfair_digraph_encrypt_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // square still all zero from reset: A found at the corner, X missing
    @(negedge clk);
    rx_eager = 1'b1;
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(LETTER_X, 1'b1, 1'b0);
    wait_idle();

    // plain alphabet square without J
    plan_square(SQ_ALPHABET);
    load_square();
    @(negedge clk);
    queue_letter(0, 1'b0, 1'b0);         // A F: same column
    queue_letter(5, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b0);         // A G: rectangle
    queue_letter(6, 1'b0, 1'b0);
    queue_letter(4, 1'b0, 1'b0);         // E A: row wraps
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(21, 1'b0, 1'b0);        // V A: column wraps
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(LETTER_J, 1'b0, 1'b0);  // J folds to I, same row as K
    queue_letter(10, 1'b0, 1'b0);
    queue_letter(11, 1'b0, 1'b0);        // doubled letter, no filler
    queue_letter(11, 1'b0, 1'b0);
    queue_letter(16, 1'b1, 1'b0);        // odd end pads with X
    queue_letter(1, 1'b0, 1'b0);         // end flag on a completing letter
    queue_letter(25, 1'b1, 1'b0);
    wait_idle();

    // codes above 25 stored, J stored instead of I, duplicate B at the bottom
    plan_square(SQ_ALPHABET);
    square_plan[0]  = '1;
    square_plan[8]  = LETTER_J;
    square_plan[12] = 5'd26;
    square_plan[23] = 5'd1;
    load_square();
    @(negedge clk);
    queue_letter('1, 1'b0, 1'b0);
    queue_letter(26, 1'b0, 1'b0);
    queue_letter(LETTER_J, 1'b0, 1'b0);  // I no longer in the square
    queue_letter(1, 1'b0, 1'b0);
    queue_letter(1, 1'b0, 1'b0);         // first B wins: same column as W
    queue_letter(22, 1'b0, 1'b0);
    queue_letter('1, 1'b1, 1'b0);
    wait_idle();

    // random messages over a range of squares and flow patterns
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      plan_square(phase_kind[p]);
      load_square();
      @(negedge clk);
      rx_eager      = (p % 4 == 2);
      rx_hold_armed = (p == 5);
      queue_messages(ITEMS_PER_PHASE, !(rx_eager || p == 5));
      wait_idle();
    end

    if (mismatch_count == 0) $display("playfair_digraph_encrypt_tb passed");
    else $display("playfair_digraph_encrypt_tb failed");
    $finish;
  end

endmodule
